// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the domino tiling score block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, off while rst_ni is low.
`define DTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the cycle after the trigger.
`define DTS_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dts_pkg.sv =====
// Shared constants, types and profile helpers of the domino tiling score block.
package dts_pkg;

  localparam int ROWS     = 3;
  localparam int PROFILES = 8;
  localparam int PROF_W   = 3;
  localparam int SLOTS    = 3;
  localparam int SLOT_W   = 2;
  localparam int OUT_BITS = 40;

  // Coverage profiles: bit 0 top, bit 1 middle, bit 2 bottom.
  localparam logic [PROF_W-1:0] PROF_NONE     = 3'd0;
  localparam logic [PROF_W-1:0] PROF_TOP_PAIR = 3'd3;
  localparam logic [PROF_W-1:0] PROF_BOT_PAIR = 3'd6;
  localparam logic [PROF_W-1:0] PROF_FULL     = 3'd7;

  // Profiles reachable after the first column of a grid.
  localparam logic [PROFILES-1:0] SEED_MASK =
    PROFILES'((1 << PROF_NONE) | (1 << PROF_TOP_PAIR) | (1 << PROF_BOT_PAIR));

  // Candidate slots of one lane: horizontal dominoes only, or with a vertical pair.
  localparam logic [SLOT_W-1:0] SLOT_STAY = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_TOP  = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_BOT  = 2'd2;

  typedef struct packed {
    logic first;
    logic last;
  } col_ctrl_t;

  // Profile of the next column that a slot of lane ps lands in.
  function automatic logic [PROF_W-1:0] dest_profile(input logic [PROF_W-1:0] ps,
                                                     input logic [SLOT_W-1:0] slot);
    logic [PROF_W-1:0] ns;
    ns = ~ps;
    case (slot)
      SLOT_STAY: dest_profile = ns;
      SLOT_TOP:  dest_profile = ns | PROF_TOP_PAIR;
      SLOT_BOT:  dest_profile = ns | PROF_BOT_PAIR;
      default:   dest_profile = ns;
    endcase
  endfunction

  // A vertical pair fits only where both of its cells are still free.
  function automatic logic slot_open(input logic [PROF_W-1:0] ps,
                                     input logic [SLOT_W-1:0] slot);
    logic [PROF_W-1:0] ns;
    ns = ~ps;
    case (slot)
      SLOT_STAY: slot_open = 1'b1;
      SLOT_TOP:  slot_open = ((ns & PROF_TOP_PAIR) == PROF_NONE);
      SLOT_BOT:  slot_open = ((ns & PROF_BOT_PAIR) == PROF_NONE);
      default:   slot_open = 1'b0;
    endcase
  endfunction

endpackage

// ===== hdl/domino_tiling_score_extremes.sv =====
// Top level of the domino tiling score block: column stage, profile lanes, result register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------------
//   column  | in        | in_valid_i / in_ready_o | top/middle/bottom_value_i, last_column_i
//   result  | out       | out_valid_o/out_ready_i | max_total_o, min_total_o, tileable_o
//
// One column is accepted per cycle unless stalled; the eight profile lanes update at once.
// out_valid_o is registered as the last column of a grid leaves the column stage.
// Reset clears the profile state and marks the next column as the first of a grid.
// A last column waits in the column stage while an untaken result occupies the
// output register; other columns keep flowing.
`include "assert_macros.svh"

module domino_tiling_score_extremes #(
  parameter int VALUE_BITS = 16,
  parameter int SCORE_BITS = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_BITS-1:0]  top_value_i,
  input  logic signed [VALUE_BITS-1:0]  middle_value_i,
  input  logic signed [VALUE_BITS-1:0]  bottom_value_i,
  input  logic                          last_column_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dts_pkg::OUT_BITS-1:0]  max_total_o,
  output logic [dts_pkg::OUT_BITS-1:0]  min_total_o,
  output logic                          tileable_o
);

  localparam int NP = dts_pkg::PROFILES;
  localparam int NS = dts_pkg::SLOTS;

  logic in_acc;
  logic s1_adv;

  logic [dts_pkg::ROWS-1:0][VALUE_BITS-1:0] col_value;
  logic [dts_pkg::ROWS-1:0][VALUE_BITS-1:0] prev_q;
  logic [NP-1:0][NS-1:0][SCORE_BITS-1:0]    inc_d;
  logic [NP-1:0][NS-1:0][SCORE_BITS-1:0]    inc_q;

  logic               fresh_q, fresh_d;
  logic               s1_vld_q, s1_vld_d;
  dts_pkg::col_ctrl_t s1_ctrl_q, s1_ctrl_d;

  logic [NP-1:0]                  reach_q, reach_d;
  logic [NP-1:0][SCORE_BITS-1:0]  best_q, best_d;
  logic [NP-1:0][SCORE_BITS-1:0]  worst_q, worst_d;

  logic [NP-1:0][NS-1:0]                  lane_open;
  logic [NP-1:0][NS-1:0]                  cand_vld;
  logic [NP-1:0][NS-1:0][SCORE_BITS-1:0]  cand_hi;
  logic [NP-1:0][NS-1:0][SCORE_BITS-1:0]  cand_lo;

  logic                          res_vld;
  logic [dts_pkg::OUT_BITS-1:0]  res_max;
  logic [dts_pkg::OUT_BITS-1:0]  res_min;
  logic                          res_tile;

  logic                          out_vld_q, out_vld_d;
  logic [dts_pkg::OUT_BITS-1:0]  out_max_q;
  logic [dts_pkg::OUT_BITS-1:0]  out_min_q;
  logic                          out_tile_q;

  assign s1_adv     = s1_vld_q & ~(s1_ctrl_q.last & out_vld_q & ~out_ready_i);
  assign in_ready_o = ~s1_vld_q | s1_adv;
  assign in_acc     = in_valid_i & in_ready_o;

  assign col_value[0] = top_value_i;
  assign col_value[1] = middle_value_i;
  assign col_value[2] = bottom_value_i;

  dts_prep #(
    .VALUE_BITS (VALUE_BITS),
    .SCORE_BITS (SCORE_BITS)
  ) u_prep (
    .value_i (col_value),
    .prev_i  (prev_q),
    .inc_o   (inc_d)
  );

  // Column stage.
  always_comb begin
    fresh_d        = fresh_q;
    s1_vld_d       = s1_vld_q & ~s1_adv;
    s1_ctrl_d      = s1_ctrl_q;
    if (in_acc) begin
      fresh_d         = last_column_i;
      s1_vld_d        = 1'b1;
      s1_ctrl_d.first = fresh_q;
      s1_ctrl_d.last  = last_column_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q   <= 1'b1;
      s1_vld_q  <= 1'b0;
      s1_ctrl_q <= '0;
    end else begin
      fresh_q   <= fresh_d;
      s1_vld_q  <= s1_vld_d;
      s1_ctrl_q <= s1_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prev_q <= col_value;
      inc_q  <= inc_d;
    end
  end

  // Profile lanes; lane ps reads the increments of its complementary profile.
  for (genvar ps = 0; ps < NP; ps++) begin : g_lane
    for (genvar s = 0; s < NS; s++) begin : g_open
      assign lane_open[ps][s] = dts_pkg::slot_open(dts_pkg::PROF_W'(ps), dts_pkg::SLOT_W'(s));
    end

    dts_lane #(
      .SCORE_BITS (SCORE_BITS)
    ) u_lane (
      .reach_i    (reach_q[ps]),
      .best_i     (best_q[ps]),
      .worst_i    (worst_q[ps]),
      .inc_i      (inc_q[dts_pkg::PROF_FULL ^ dts_pkg::PROF_W'(ps)]),
      .open_i     (lane_open[ps]),
      .cand_vld_o (cand_vld[ps]),
      .cand_hi_o  (cand_hi[ps]),
      .cand_lo_o  (cand_lo[ps])
    );
  end

  dts_merge #(
    .SCORE_BITS (SCORE_BITS)
  ) u_merge (
    .ctrl_i       (s1_ctrl_q),
    .seed_top_i   (inc_q[dts_pkg::PROF_NONE][dts_pkg::SLOT_TOP]),
    .seed_bot_i   (inc_q[dts_pkg::PROF_NONE][dts_pkg::SLOT_BOT]),
    .cand_vld_i   (cand_vld),
    .cand_hi_i    (cand_hi),
    .cand_lo_i    (cand_lo),
    .next_reach_o (reach_d),
    .next_best_o  (best_d),
    .next_worst_o (worst_d),
    .res_vld_o    (res_vld),
    .res_max_o    (res_max),
    .res_min_o    (res_min),
    .res_tile_o   (res_tile)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q <= '0;
      best_q  <= '0;
      worst_q <= '0;
    end else if (s1_adv) begin
      reach_q <= reach_d;
      best_q  <= best_d;
      worst_q <= worst_d;
    end
  end

  // Result register.
  always_comb begin
    out_vld_d = out_vld_q & ~out_ready_i;
    if (s1_adv && res_vld) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_vld) begin
      out_max_q  <= res_max;
      out_min_q  <= res_min;
      out_tile_q <= res_tile;
    end
  end

  assign out_valid_o = out_vld_q;
  assign max_total_o = out_max_q;
  assign min_total_o = out_min_q;
  assign tileable_o  = out_tile_q;

  `DTS_ASSERT_NEXT(a_last_gives_result, s1_adv && s1_ctrl_q.last, out_vld_q, "last column lost its result")
  `DTS_ASSERT_NEXT(a_last_rearms_grid, in_acc && last_column_i, fresh_q, "grid not rearmed after last column")
  `DTS_ASSERT_NEXT(a_first_seeds, s1_adv && s1_ctrl_q.first, reach_q == dts_pkg::SEED_MASK, "first column seeded wrong profiles")
  `DTS_ASSERT(a_untileable_zero, !(out_vld_q && !out_tile_q) || (out_max_q == '0 && out_min_q == '0), "untileable result carries totals")
  `DTS_ASSERT(a_min_le_max, !(out_vld_q && out_tile_q) || (out_min_q <= out_max_q), "minimum total above maximum")

endmodule

// ===== hdl/dts_prep.sv =====
// Column preparation: cell differences and saturated increments per next profile.
module dts_prep #(
  parameter int VALUE_BITS = 16,
  parameter int SCORE_BITS = 40
) (
  input  logic [dts_pkg::ROWS-1:0][VALUE_BITS-1:0]     value_i,
  input  logic [dts_pkg::ROWS-1:0][VALUE_BITS-1:0]     prev_i,
  output logic [dts_pkg::PROFILES-1:0][dts_pkg::SLOTS-1:0][SCORE_BITS-1:0] inc_o
);

  localparam int SUM_W = VALUE_BITS + 2;
  localparam int EXT_W = (SUM_W > SCORE_BITS) ? SUM_W : SCORE_BITS;

  function automatic logic [VALUE_BITS-1:0] abs_diff(input logic [VALUE_BITS-1:0] a,
                                                     input logic [VALUE_BITS-1:0] b);
    logic [VALUE_BITS:0] d;
    logic [VALUE_BITS:0] mag;
    d   = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
    mag = d[VALUE_BITS] ? (~d + 1'b1) : d;
    return mag[VALUE_BITS-1:0];
  endfunction

  function automatic logic [SCORE_BITS-1:0] clamp(input logic [SUM_W-1:0] sum);
    logic [EXT_W-1:0] e;
    logic [EXT_W-1:0] cap;
    e   = EXT_W'(sum);
    cap = EXT_W'({SCORE_BITS{1'b1}});
    return (e > cap) ? cap[SCORE_BITS-1:0] : e[SCORE_BITS-1:0];
  endfunction

  logic [dts_pkg::ROWS-1:0][VALUE_BITS-1:0] cell_diff;
  logic [VALUE_BITS-1:0] d01;
  logic [VALUE_BITS-1:0] d12;

  always_comb begin
    for (int k = 0; k < dts_pkg::ROWS; k++) begin
      cell_diff[k] = abs_diff(value_i[k], prev_i[k]);
    end
    d01 = abs_diff(value_i[0], value_i[1]);
    d12 = abs_diff(value_i[1], value_i[2]);
  end

  // Horizontal dominoes close every cell that the next profile marks covered.
  always_comb begin : inc_comb
    logic [SUM_W-1:0] h;
    for (int ns = 0; ns < dts_pkg::PROFILES; ns++) begin
      h = '0;
      for (int k = 0; k < dts_pkg::ROWS; k++) begin
        if (ns[k]) begin
          h = h + SUM_W'(cell_diff[k]);
        end
      end
      inc_o[ns][dts_pkg::SLOT_STAY] = clamp(h);
      inc_o[ns][dts_pkg::SLOT_TOP]  = clamp(h + SUM_W'(d01));
      inc_o[ns][dts_pkg::SLOT_BOT]  = clamp(h + SUM_W'(d12));
    end
  end

endmodule

// ===== hdl/dts_lane.sv =====
// One profile lane: extends its best and worst scores into up to three candidates.
module dts_lane #(
  parameter int SCORE_BITS = 40
) (
  input  logic                                       reach_i,
  input  logic [SCORE_BITS-1:0]                      best_i,
  input  logic [SCORE_BITS-1:0]                      worst_i,
  input  logic [dts_pkg::SLOTS-1:0][SCORE_BITS-1:0]  inc_i,
  input  logic [dts_pkg::SLOTS-1:0]                  open_i,
  output logic [dts_pkg::SLOTS-1:0]                  cand_vld_o,
  output logic [dts_pkg::SLOTS-1:0][SCORE_BITS-1:0]  cand_hi_o,
  output logic [dts_pkg::SLOTS-1:0][SCORE_BITS-1:0]  cand_lo_o
);

  function automatic logic [SCORE_BITS-1:0] sat_add(input logic [SCORE_BITS-1:0] a,
                                                    input logic [SCORE_BITS-1:0] b);
    logic [SCORE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SCORE_BITS] ? {SCORE_BITS{1'b1}} : s[SCORE_BITS-1:0];
  endfunction

  always_comb begin
    for (int s = 0; s < dts_pkg::SLOTS; s++) begin
      cand_vld_o[s] = reach_i & open_i[s];
      cand_hi_o[s]  = sat_add(best_i, inc_i[s]);
      cand_lo_o[s]  = sat_add(worst_i, inc_i[s]);
    end
  end

endmodule

// ===== hdl/dts_merge.sv =====
// Merge of lane candidates into the next profile state, with the grid result.
module dts_merge #(
  parameter int SCORE_BITS = 40
) (
  input  dts_pkg::col_ctrl_t                          ctrl_i,
  input  logic [SCORE_BITS-1:0]                       seed_top_i,
  input  logic [SCORE_BITS-1:0]                       seed_bot_i,
  input  logic [dts_pkg::PROFILES-1:0][dts_pkg::SLOTS-1:0]                 cand_vld_i,
  input  logic [dts_pkg::PROFILES-1:0][dts_pkg::SLOTS-1:0][SCORE_BITS-1:0] cand_hi_i,
  input  logic [dts_pkg::PROFILES-1:0][dts_pkg::SLOTS-1:0][SCORE_BITS-1:0] cand_lo_i,
  output logic [dts_pkg::PROFILES-1:0]                  next_reach_o,
  output logic [dts_pkg::PROFILES-1:0][SCORE_BITS-1:0]  next_best_o,
  output logic [dts_pkg::PROFILES-1:0][SCORE_BITS-1:0]  next_worst_o,
  output logic                                          res_vld_o,
  output logic [dts_pkg::OUT_BITS-1:0]                  res_max_o,
  output logic [dts_pkg::OUT_BITS-1:0]                  res_min_o,
  output logic                                          res_tile_o
);

  localparam int EXT_W = (SCORE_BITS > dts_pkg::OUT_BITS) ? SCORE_BITS : dts_pkg::OUT_BITS;

  logic [EXT_W-1:0] full_best_ext;
  logic [EXT_W-1:0] full_worst_ext;

  // The lane-to-profile map is fixed, so each profile compares at most three candidates.
  always_comb begin : merge_comb
    logic [dts_pkg::PROF_W-1:0] dst;
    next_reach_o = '0;
    next_best_o  = '0;
    next_worst_o = '0;
    for (int ps = 0; ps < dts_pkg::PROFILES; ps++) begin
      for (int s = 0; s < dts_pkg::SLOTS; s++) begin
        dst = dts_pkg::dest_profile(dts_pkg::PROF_W'(ps), dts_pkg::SLOT_W'(s));
        if (cand_vld_i[ps][s]) begin
          if (!next_reach_o[dst] || (cand_hi_i[ps][s] > next_best_o[dst])) begin
            next_best_o[dst] = cand_hi_i[ps][s];
          end
          if (!next_reach_o[dst] || (cand_lo_i[ps][s] < next_worst_o[dst])) begin
            next_worst_o[dst] = cand_lo_i[ps][s];
          end
          next_reach_o[dst] = 1'b1;
        end
      end
    end
    if (ctrl_i.first) begin
      next_reach_o = dts_pkg::SEED_MASK;
      next_best_o  = '0;
      next_worst_o = '0;
      next_best_o[dts_pkg::PROF_TOP_PAIR]  = seed_top_i;
      next_worst_o[dts_pkg::PROF_TOP_PAIR] = seed_top_i;
      next_best_o[dts_pkg::PROF_BOT_PAIR]  = seed_bot_i;
      next_worst_o[dts_pkg::PROF_BOT_PAIR] = seed_bot_i;
    end
  end

  assign full_best_ext  = EXT_W'(next_best_o[dts_pkg::PROF_FULL]);
  assign full_worst_ext = EXT_W'(next_worst_o[dts_pkg::PROF_FULL]);

  assign res_vld_o  = ctrl_i.last;
  assign res_tile_o = next_reach_o[dts_pkg::PROF_FULL];
  assign res_max_o  = res_tile_o ? full_best_ext[dts_pkg::OUT_BITS-1:0] : '0;
  assign res_min_o  = res_tile_o ? full_worst_ext[dts_pkg::OUT_BITS-1:0] : '0;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the three-row domino tiling score extremes block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OUT_BITS = dts_pkg::OUT_BITS;
  localparam int PROFILES = dts_pkg::PROFILES;
  localparam int ROWS     = dts_pkg::ROWS;
  localparam int PROF_W   = dts_pkg::PROF_W;
  localparam logic [PROF_W-1:0]   PROF_NONE     = dts_pkg::PROF_NONE;
  localparam logic [PROF_W-1:0]   PROF_TOP_PAIR = dts_pkg::PROF_TOP_PAIR;
  localparam logic [PROF_W-1:0]   PROF_BOT_PAIR = dts_pkg::PROF_BOT_PAIR;
  localparam logic [PROF_W-1:0]   PROF_FULL     = dts_pkg::PROF_FULL;
  localparam logic [PROFILES-1:0] SEED_MASK     = dts_pkg::SEED_MASK;

  localparam int VALUE_BITS = 16;
  localparam int SCORE_BITS = 40;
  localparam int TOTAL_ITEMS = 1850;

  typedef logic [OUT_BITS-1:0] score_t;
  typedef logic signed [VALUE_BITS-1:0] cell_t;

  typedef struct packed {
    score_t hi;
    score_t lo;
    logic   ok;
  } grid_total_t;

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  cell_t  top_value_i;
  cell_t  middle_value_i;
  cell_t  bottom_value_i;
  logic   last_column_i;
  logic   out_valid_o;
  logic   out_ready_i;
  score_t max_total_o;
  score_t min_total_o;
  logic   tileable_o;

  domino_tiling_score_extremes #(
    .VALUE_BITS(VALUE_BITS),
    .SCORE_BITS(SCORE_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .top_value_i    (top_value_i),
    .middle_value_i (middle_value_i),
    .bottom_value_i (bottom_value_i),
    .last_column_i  (last_column_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .max_total_o    (max_total_o),
    .min_total_o    (min_total_o),
    .tileable_o     (tileable_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Tiling predictor state, one best and one worst running score per coverage profile.
  score_t            best_run [PROFILES];
  score_t            worst_run[PROFILES];
  logic [PROFILES-1:0] reach_run;
  logic              grid_start;
  cell_t             prev_cells[ROWS];

  score_t            best_nxt [PROFILES];
  score_t            worst_nxt[PROFILES];
  logic [PROFILES-1:0] reach_nxt;

  grid_total_t totals_due[$];
  int          fault_count;
  int          items_sent;

  function automatic score_t sat_add(score_t a, score_t b);
    logic [OUT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OUT_BITS] ? '1 : s[OUT_BITS-1:0];
  endfunction

  function automatic score_t cell_gap(cell_t a, cell_t b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    return score_t'(d);
  endfunction

  function automatic void offer(logic [PROF_W-1:0] prof, score_t hi, score_t lo);
    if (!reach_nxt[prof]) begin
      best_nxt[prof]  = hi;
      worst_nxt[prof] = lo;
      reach_nxt[prof] = 1'b1;
    end else begin
      if (hi > best_nxt[prof]) best_nxt[prof] = hi;
      if (lo < worst_nxt[prof]) worst_nxt[prof] = lo;
    end
  endfunction

  function automatic void clear_grid();
    for (int k = 0; k < PROFILES; k++) begin
      best_run[k]  = '0;
      worst_run[k] = '0;
    end
    for (int k = 0; k < ROWS; k++) prev_cells[k] = '0;
    reach_run  = '0;
    grid_start = 1'b1;
  endfunction

  // Advances the tiling recurrence by one accepted column; a last column queues its totals.
  function automatic void absorb_column(cell_t t, cell_t m, cell_t b, logic last);
    cell_t             v[ROWS];
    score_t            d01, d12, h, hb, hw;
    logic [PROF_W-1:0] ns;
    grid_total_t       r;
    v[0] = t;
    v[1] = m;
    v[2] = b;
    d01 = cell_gap(t, m);
    d12 = cell_gap(m, b);
    if (grid_start) begin
      for (int k = 0; k < PROFILES; k++) begin
        best_run[k]  = '0;
        worst_run[k] = '0;
      end
      best_run[PROF_TOP_PAIR]  = d01;
      worst_run[PROF_TOP_PAIR] = d01;
      best_run[PROF_BOT_PAIR]  = d12;
      worst_run[PROF_BOT_PAIR] = d12;
      reach_run  = SEED_MASK;
      grid_start = 1'b0;
    end else begin
      reach_nxt = '0;
      for (int k = 0; k < PROFILES; k++) begin
        best_nxt[k]  = '0;
        worst_nxt[k] = '0;
      end
      for (int ps = 0; ps < PROFILES; ps++) begin
        if (reach_run[ps]) begin
          ns = ~PROF_W'(ps);
          h  = '0;
          // Every cell left open in the previous column takes a horizontal domino.
          for (int k = 0; k < ROWS; k++)
            if (ns[k]) h = sat_add(h, cell_gap(v[k], prev_cells[k]));
          hb = sat_add(best_run[ps], h);
          hw = sat_add(worst_run[ps], h);
          offer(ns, hb, hw);
          if ((ns & PROF_TOP_PAIR) == PROF_NONE)
            offer(ns | PROF_TOP_PAIR, sat_add(hb, d01), sat_add(hw, d01));
          if ((ns & PROF_BOT_PAIR) == PROF_NONE)
            offer(ns | PROF_BOT_PAIR, sat_add(hb, d12), sat_add(hw, d12));
        end
      end
      best_run  = best_nxt;
      worst_run = worst_nxt;
      reach_run = reach_nxt;
    end
    for (int k = 0; k < ROWS; k++) prev_cells[k] = v[k];
    if (last) begin
      if (reach_run[PROF_FULL]) begin
        r.hi = best_run[PROF_FULL];
        r.lo = worst_run[PROF_FULL];
        r.ok = 1'b1;
      end else begin
        r = '0;
      end
      totals_due.push_back(r);
      clear_grid();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_column(cell_t t, cell_t m, cell_t b, logic last, bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    top_value_i    <= t;
    middle_value_i <= m;
    bottom_value_i <= b;
    last_column_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb_column(t, m, b, last);
    items_sent++;
  endtask

  // Holds the column channel idle until every queued grid total has been checked.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: each accepted transaction against the oldest queued grid total.
  always @(posedge clk_i) begin
    grid_total_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (totals_due.size() == 0) begin
        $error("result transaction with no grid outstanding");
        fault_count++;
      end else begin
        want = totals_due.pop_front();
        if (max_total_o !== want.hi) begin
          $error("max_total expected %0d actual %0d", want.hi, max_total_o);
          fault_count++;
        end
        if (min_total_o !== want.lo) begin
          $error("min_total expected %0d actual %0d", want.lo, min_total_o);
          fault_count++;
        end
        if (tileable_o !== want.ok) begin
          $error("tileable expected %0d actual %0d", want.ok, tileable_o);
          fault_count++;
        end
      end
    end
  end

  // Result backpressure: short stalls mostly, a few long ones, and long stall-free stretches.
  initial begin
    int hi_len, lo_len, r;
    @(posedge rst_ni);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        hi_len = $urandom_range(100, 300);
        lo_len = 0;
      end else begin
        hi_len = $urandom_range(1, 8);
        lo_len = (r < 92) ? $urandom_range(1, 4) : $urandom_range(15, 50);
      end
      out_ready_i <= 1'b1;
      repeat (hi_len) @(posedge clk_i);
      if (lo_len != 0) begin
        out_ready_i <= 1'b0;
        repeat (lo_len) @(posedge clk_i);
      end
    end
  end

  task automatic test_single_column();
    send_column(16'sd5, -16'sd7, 16'sd100, 1'b1, 1'b0);
  endtask

  task automatic test_two_column_extremes();
    send_column(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 1'b0);
    send_column(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1, 1'b0);
  endtask

  task automatic test_odd_grid();
    send_column(16'sd1, 16'sd2, 16'sd3, 1'b0, 1'b1);
    send_column(-16'sd4, 16'sd9, -16'sd1, 1'b0, 1'b1);
    send_column(16'sd0, 16'sd8, 16'sd2, 1'b1, 1'b1);
  endtask

  task automatic test_flat_grid();
    repeat (3) send_column(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
    send_column(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);
  endtask

  task automatic test_alternating_extremes();
    send_column(16'sh8000, 16'sh7fff, -16'sd1, 1'b0, 1'b1);
    send_column(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 1'b1);
    send_column(-16'sd1, 16'sh7fff, 16'sh8000, 1'b0, 1'b1);
    send_column(16'sh8000, -16'sd1, 16'sh7fff, 1'b0, 1'b1);
    send_column(16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, 1'b1);
    send_column(16'sh8000, 16'sh7fff, -16'sd1, 1'b1, 1'b1);
  endtask

  function automatic cell_t pick_value(int style, cell_t base);
    int sel;
    case (style)
      0: return cell_t'($urandom);
      1: return cell_t'($urandom_range(0, 8) - 4);
      2: begin
        sel = $urandom_range(0, 3);
        case (sel)
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: return cell_t'(int'(base) + $urandom_range(0, 6) - 3);
    endcase
  endfunction

  function automatic int pick_grid_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 2 * $urandom_range(1, 6);
    if (r < 80) return 2 * $urandom_range(0, 5) + 1;
    if (r < 92) return 2 * $urandom_range(7, 20);
    return 2;
  endfunction

  task automatic test_random_grids(int budget);
    int    len, style, stop_at;
    bit    burst, paused;
    cell_t base;
    stop_at = items_sent + budget;
    paused  = 1'b0;
    while (items_sent < stop_at) begin
      len   = pick_grid_len();
      style = $urandom_range(0, 3);
      burst = ($urandom_range(0, 5) == 0);
      base  = cell_t'($urandom);
      for (int c = 0; c < len; c++)
        send_column(pick_value(style, base), pick_value(style, base),
                    pick_value(style, base), c == len - 1, burst);
      if (!paused && items_sent > stop_at - budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    fault_count    = 0;
    items_sent     = 0;
    clear_grid();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    top_value_i    = '0;
    middle_value_i = '0;
    bottom_value_i = '0;
    last_column_i  = 1'b0;
    out_ready_i    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_column();
    test_two_column_extremes();
    test_odd_grid();
    wait_drained();
    test_flat_grid();
    test_alternating_extremes();
    test_random_grids(TOTAL_ITEMS - items_sent);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("[domino_tiling_score_extremes] OK");
    end else begin
      $display("[domino_tiling_score_extremes] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung run; the limit leaves a wide margin over the slowest legal run.
  initial begin
    #8ms;
    $display("[domino_tiling_score_extremes] ERROR");
    $finish;
  end

endmodule
